// File: hw/rtl/psd_pkg.sv
// psd_pkg: shared widths, case codes and the coordinate bundle for the
// point-to-segment squared distance pipeline. No dependencies.
package psd_pkg;

  localparam int COORD_W  = 31;  // signed Q14.16 coordinate
  localparam int DIFF_W   = 32;  // difference of two coordinates
  localparam int PROD_W   = 64;  // product of two differences
  localparam int LEN_W    = 63;  // |E-S|^2 fits below 2^63
  localparam int THR_W    = 32;
  localparam int DIST_W   = 64;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int T_FRAC_BITS_DEF     = 24;

  localparam logic [THR_W-1:0] THR_RESET = 32'd43;

  typedef enum logic [1:0] {
    CASE_INTERIOR = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2,
    CASE_ON_SEG   = 2'd3
  } case_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } pts_t;

endpackage

// File: hw/rtl/psd_front.sv
// psd_front: differences, products, then dot product and squared length.
// Three register stages; depends on psd_pkg.
module psd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_stall,
  input  psd_pkg::pts_t               up_pts,
  input  logic                        dn_ready,
  output logic                        dn_valid,
  output psd_pkg::pts_t               dn_pts,
  output logic [psd_pkg::PROD_W-1:0]  dn_dot,
  output logic [psd_pkg::LEN_W-1:0]   dn_len2
);

  localparam int DW = psd_pkg::DIFF_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int CW = psd_pkg::COORD_W;

  logic va_r, vb_r, vc_r;
  logic en_a, en_b, en_c;

  psd_pkg::pts_t pa_r, pb_r, pc_r;
  logic signed [DW-1:0] apx_r, apy_r, dx_r, dy_r;
  logic signed [PW-1:0] mxd_r, myd_r, dxx_r, dyy_r;
  logic [PW-1:0] dot_r;
  logic [psd_pkg::LEN_W-1:0] len2_r;

  logic signed [DW-1:0] apx_nxt, apy_nxt, dx_nxt, dy_nxt;
  logic [PW-1:0] lsum;

  assign en_c = !vc_r || dn_ready;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign up_stall = !en_a;

  assign apx_nxt = {up_pts.px[CW-1], up_pts.px} - {up_pts.sx[CW-1], up_pts.sx};
  assign apy_nxt = {up_pts.py[CW-1], up_pts.py} - {up_pts.sy[CW-1], up_pts.sy};
  assign dx_nxt  = {up_pts.ex[CW-1], up_pts.ex} - {up_pts.sx[CW-1], up_pts.sx};
  assign dy_nxt  = {up_pts.ey[CW-1], up_pts.ey} - {up_pts.sy[CW-1], up_pts.sy};

  assign lsum = dxx_r + dyy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      pa_r  <= up_pts;
      apx_r <= apx_nxt;
      apy_r <= apy_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
    end
    if (en_b && va_r) begin
      pb_r  <= pa_r;
      mxd_r <= apx_r * dx_r;
      myd_r <= apy_r * dy_r;
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
    end
    if (en_c && vb_r) begin
      pc_r   <= pb_r;
      dot_r  <= mxd_r + myd_r;
      len2_r <= lsum[psd_pkg::LEN_W-1:0];
    end
  end

  assign dn_valid = vc_r;
  assign dn_pts   = pc_r;
  assign dn_dot   = dot_r;
  assign dn_len2  = len2_r;

endmodule

// File: hw/rtl/psd_div.sv
// psd_div: classify the projection and form t = dot/len2 one quotient bit
// per stage (restoring division). Depends on psd_pkg.
module psd_div #(
  parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  psd_pkg::pts_t               up_pts,
  input  logic [psd_pkg::PROD_W-1:0]  up_dot,
  input  logic [psd_pkg::LEN_W-1:0]   up_len2,
  input  logic                        dn_ready,
  output logic                        dn_valid,
  output psd_pkg::pts_t               dn_pts,
  output psd_pkg::case_t              dn_case,
  output logic [T_FRAC_BITS:0]        dn_t
);

  localparam int LW = psd_pkg::LEN_W;
  localparam int NS = T_FRAC_BITS + 1;

  logic           v_r   [NS];
  logic           en    [NS+1];
  psd_pkg::pts_t  pts_r [NS];
  psd_pkg::case_t cs_r  [NS];
  logic [LW-1:0]  den_r [NS];
  logic [LW-1:0]  rem_r [NS];
  logic [T_FRAC_BITS:0] q_r [NS];

  logic [LW-1:0] dot_u;
  logic dot_neg, len_zero, whole, beyond;
  psd_pkg::case_t cs0;

  assign en[NS] = dn_ready;
  assign up_ready = en[0];

  assign dot_u    = up_dot[LW-1:0];
  assign dot_neg  = up_dot[psd_pkg::PROD_W-1];
  assign len_zero = (up_len2 == '0);
  assign whole    = !(dot_u < up_len2);
  assign beyond   = dot_u > up_len2;

  always_comb begin
    if (len_zero || dot_neg) cs0 = psd_pkg::CASE_START;
    else if (beyond)         cs0 = psd_pkg::CASE_END;
    else                     cs0 = psd_pkg::CASE_INTERIOR;
  end

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      assign en[k] = !v_r[k] || en[k+1];
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) v_r[0] <= 1'b0;
          else if (en[0]) v_r[0] <= up_valid;
        end
        always_ff @(posedge clk) begin
          if (en[0] && up_valid) begin
            pts_r[0] <= up_pts;
            cs_r[0]  <= cs0;
            den_r[0] <= up_len2;
            rem_r[0] <= whole ? dot_u - up_len2 : dot_u;
            q_r[0]   <= {{T_FRAC_BITS{1'b0}}, whole};
          end
        end
      end else begin : g_bit
        logic [LW:0] rs, diff;
        logic ge;
        assign rs   = {rem_r[k-1], 1'b0};
        assign diff = rs - {1'b0, den_r[k-1]};
        assign ge   = !(rs < {1'b0, den_r[k-1]});
        always_ff @(posedge clk) begin
          if (!rst_n) v_r[k] <= 1'b0;
          else if (en[k]) v_r[k] <= v_r[k-1];
        end
        always_ff @(posedge clk) begin
          if (en[k] && v_r[k-1]) begin
            pts_r[k] <= pts_r[k-1];
            cs_r[k]  <= cs_r[k-1];
            den_r[k] <= den_r[k-1];
            rem_r[k] <= ge ? diff[LW-1:0] : rs[LW-1:0];
            q_r[k]   <= {q_r[k-1][T_FRAC_BITS-1:0], ge};
          end
        end
      end
    end
  endgenerate

  assign dn_valid = v_r[NS-1];
  assign dn_pts   = pts_r[NS-1];
  assign dn_case  = cs_r[NS-1];
  assign dn_t     = q_r[NS-1];

endmodule

// File: hw/rtl/psd_near.sv
// psd_near: nearest point by interpolation or clamp, residual, squared
// distance, Q32.32 scaling and the on-segment test. Depends on psd_pkg.
module psd_near #(
  parameter int COORD_FRAC_BITS = psd_pkg::COORD_FRAC_BITS_DEF,
  parameter int T_FRAC_BITS     = psd_pkg::T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  psd_pkg::pts_t                up_pts,
  input  psd_pkg::case_t               up_case,
  input  logic [T_FRAC_BITS:0]         up_t,
  input  logic [psd_pkg::THR_W-1:0]    thr,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [psd_pkg::COORD_W-1:0]  nearest_x,
  output logic [psd_pkg::COORD_W-1:0]  nearest_y,
  output logic [psd_pkg::DIST_W-1:0]   squared_distance,
  output logic [1:0]                   which_case
);

  localparam int CW = psd_pkg::COORD_W;
  localparam int DW = psd_pkg::DIFF_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int QW = psd_pkg::DIST_W;
  localparam int MW = CW + T_FRAC_BITS + 1;
  localparam int FB = 2 * COORD_FRAC_BITS;
  localparam logic [MW-1:0] HALF = MW'(1) << (T_FRAC_BITS - 1);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  psd_pkg::pts_t  p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  psd_pkg::case_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  logic [T_FRAC_BITS:0] t1_r;
  logic [CW-1:0] magx1_r, magy1_r;
  logic          negx1_r, negy1_r, negx2_r, negy2_r, negx3_r, negy3_r;
  logic [MW-1:0] mx2_r, my2_r;
  logic [DW-1:0] offx3_r, offy3_r;
  logic [CW-1:0] nx4_r, ny4_r, nx5_r, ny5_r, nx6_r, ny6_r, nx7_r, ny7_r;
  logic signed [DW-1:0] rx5_r, ry5_r;
  logic [PW-1:0] sqx6_r, sqy6_r;
  logic [PW-1:0] raw7_r;

  logic negx_nxt, negy_nxt;
  logic [MW-1:0] rndx, rndy;
  logic [DW-1:0] ix, iy;
  logic [CW-1:0] nx_nxt, ny_nxt;
  logic [QW-1:0] sq_dist;
  logic on_seg;

  assign en8 = !v8_r || !out_stall;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;

  assign negx_nxt = $signed(up_pts.ex) < $signed(up_pts.sx);
  assign negy_nxt = $signed(up_pts.ey) < $signed(up_pts.sy);

  assign rndx = mx2_r + HALF;
  assign rndy = my2_r + HALF;

  // offset rounded ties away from zero, applied with the sign of E-S
  assign ix = negx3_r ? {p3_r.sx[CW-1], p3_r.sx} - offx3_r
                      : {p3_r.sx[CW-1], p3_r.sx} + offx3_r;
  assign iy = negy3_r ? {p3_r.sy[CW-1], p3_r.sy} - offy3_r
                      : {p3_r.sy[CW-1], p3_r.sy} + offy3_r;

  always_comb begin
    case (c3_r)
      psd_pkg::CASE_START: begin
        nx_nxt = p3_r.sx;
        ny_nxt = p3_r.sy;
      end
      psd_pkg::CASE_END: begin
        nx_nxt = p3_r.ex;
        ny_nxt = p3_r.ey;
      end
      default: begin
        nx_nxt = ix[CW-1:0];
        ny_nxt = iy[CW-1:0];
      end
    endcase
  end

  generate
    if (FB < 32) begin : g_up
      localparam int SH = 32 - FB;
      assign sq_dist = (|raw7_r[PW-1 -: SH]) ? {QW{1'b1}} : (raw7_r << SH);
    end else begin : g_down
      assign sq_dist = raw7_r >> (FB - 32);
    end
  endgenerate

  assign on_seg = !(sq_dist > {{(QW-psd_pkg::THR_W){1'b0}}, thr});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      p1_r    <= up_pts;
      c1_r    <= up_case;
      t1_r    <= up_t;
      negx1_r <= negx_nxt;
      negy1_r <= negy_nxt;
      magx1_r <= negx_nxt ? up_pts.sx - up_pts.ex : up_pts.ex - up_pts.sx;
      magy1_r <= negy_nxt ? up_pts.sy - up_pts.ey : up_pts.ey - up_pts.sy;
    end
    if (en2 && v1_r) begin
      p2_r    <= p1_r;
      c2_r    <= c1_r;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
      mx2_r   <= MW'(magx1_r) * MW'(t1_r);
      my2_r   <= MW'(magy1_r) * MW'(t1_r);
    end
    if (en3 && v2_r) begin
      p3_r    <= p2_r;
      c3_r    <= c2_r;
      negx3_r <= negx2_r;
      negy3_r <= negy2_r;
      offx3_r <= DW'(rndx[MW-1:T_FRAC_BITS]);
      offy3_r <= DW'(rndy[MW-1:T_FRAC_BITS]);
    end
    if (en4 && v3_r) begin
      p4_r  <= p3_r;
      c4_r  <= c3_r;
      nx4_r <= nx_nxt;
      ny4_r <= ny_nxt;
    end
    if (en5 && v4_r) begin
      p5_r  <= p4_r;
      c5_r  <= c4_r;
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
      rx5_r <= {p4_r.px[CW-1], p4_r.px} - {nx4_r[CW-1], nx4_r};
      ry5_r <= {p4_r.py[CW-1], p4_r.py} - {ny4_r[CW-1], ny4_r};
    end
    if (en6 && v5_r) begin
      p6_r   <= p5_r;
      c6_r   <= c5_r;
      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      sqx6_r <= rx5_r * rx5_r;
      sqy6_r <= ry5_r * ry5_r;
    end
    if (en7 && v6_r) begin
      p7_r   <= p6_r;
      c7_r   <= c6_r;
      nx7_r  <= nx6_r;
      ny7_r  <= ny6_r;
      raw7_r <= sqx6_r + sqy6_r;
    end
    if (en8 && v7_r) begin
      nearest_x        <= on_seg ? p7_r.px : nx7_r;
      nearest_y        <= on_seg ? p7_r.py : ny7_r;
      squared_distance <= on_seg ? '0 : sq_dist;
      which_case       <= on_seg ? psd_pkg::CASE_ON_SEG : c7_r;
    end
  end

  assign out_valid = v8_r;

endmodule

// File: hw/rtl/point_segment_sqr_distance_top.sv
// Point-to-segment squared distance: one query per clock unless stalled, fully pipelined.
// Three stages form the dot product and squared length, T_FRAC_BITS + 1 stages
// divide one quotient bit each, and eight stages interpolate, square, scale
// and test against the threshold. Empty stages close up under a downstream
// stall. The threshold register may be written at any time the pipe is empty.
// Depends on psd_pkg, psd_front, psd_div and psd_near.
module point_segment_sqr_distance_top #(
  parameter int COORD_FRAC_BITS = psd_pkg::COORD_FRAC_BITS_DEF,
  parameter int T_FRAC_BITS     = psd_pkg::T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [psd_pkg::COORD_W-1:0]  in_point_x,
  input  logic [psd_pkg::COORD_W-1:0]  in_point_y,
  input  logic [psd_pkg::COORD_W-1:0]  in_start_x,
  input  logic [psd_pkg::COORD_W-1:0]  in_start_y,
  input  logic [psd_pkg::COORD_W-1:0]  in_end_x,
  input  logic [psd_pkg::COORD_W-1:0]  in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [psd_pkg::COORD_W-1:0]  out_nearest_x,
  output logic [psd_pkg::COORD_W-1:0]  out_nearest_y,
  output logic [psd_pkg::DIST_W-1:0]   out_squared_distance,
  output logic [1:0]                   out_which_case,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [psd_pkg::THR_W-1:0]    cfg_data
);

  logic [psd_pkg::THR_W-1:0] thr_r;

  psd_pkg::pts_t in_pts, f_pts, d_pts;
  logic f_valid, f_ready, d_valid, d_ready;
  logic [psd_pkg::PROD_W-1:0] f_dot;
  logic [psd_pkg::LEN_W-1:0]  f_len2;
  psd_pkg::case_t d_case;
  logic [T_FRAC_BITS:0] d_t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= psd_pkg::THR_RESET;
    else if (cfg_valid) thr_r <= cfg_data;
  end

  assign in_pts = '{px: in_point_x, py: in_point_y, sx: in_start_x,
                    sy: in_start_y, ex: in_end_x, ey: in_end_y};

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_pts   (in_pts),
    .dn_ready (f_ready),
    .dn_valid (f_valid),
    .dn_pts   (f_pts),
    .dn_dot   (f_dot),
    .dn_len2  (f_len2)
  );

  psd_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_pts   (f_pts),
    .up_dot   (f_dot),
    .up_len2  (f_len2),
    .dn_ready (d_ready),
    .dn_valid (d_valid),
    .dn_pts   (d_pts),
    .dn_case  (d_case),
    .dn_t     (d_t)
  );

  psd_near #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .T_FRAC_BITS     (T_FRAC_BITS)
  ) u_near (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (d_valid),
    .up_ready         (d_ready),
    .up_pts           (d_pts),
    .up_case          (d_case),
    .up_t             (d_t),
    .thr              (thr_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .nearest_x        (out_nearest_x),
    .nearest_y        (out_nearest_y),
    .squared_distance (out_squared_distance),
    .which_case       (out_which_case)
  );

endmodule

// File: test/point_segment_sqr_distance_checker.sv
`timescale 1ns / 1ps
// Watches the query, result and threshold channels of point_segment_sqr_distance_top,
// predicts each nearest point and squared distance, and compares. Depends on psd_pkg.
module point_segment_sqr_distance_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [psd_pkg::COORD_W-1:0] in_point_x,
  input  logic [psd_pkg::COORD_W-1:0] in_point_y,
  input  logic [psd_pkg::COORD_W-1:0] in_start_x,
  input  logic [psd_pkg::COORD_W-1:0] in_start_y,
  input  logic [psd_pkg::COORD_W-1:0] in_end_x,
  input  logic [psd_pkg::COORD_W-1:0] in_end_y,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [psd_pkg::COORD_W-1:0] out_nearest_x,
  input  logic [psd_pkg::COORD_W-1:0] out_nearest_y,
  input  logic [psd_pkg::DIST_W-1:0]  out_squared_distance,
  input  logic [1:0]                  out_which_case,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [psd_pkg::THR_W-1:0]   cfg_data,
  output int                          errors,
  output int                          pending,
  output int                          results_checked
);
  import psd_pkg::*;

  localparam int TFB = T_FRAC_BITS_DEF;
  localparam int FB2 = 2 * COORD_FRAC_BITS_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [DIST_W-1:0]  sq_dist;
    case_t              which;
  } nearest_t;

  nearest_t            expected_q[$];
  logic [THR_W-1:0]    threshold;
  int                  case_seen[4];

  // floor(num * 2^TFB / den), num <= den
  function automatic logic [63:0] t_fraction(logic [63:0] num, logic [63:0] den);
    logic [63:0] whole, r, q;
    whole = (num >= den) ? 64'd1 : 64'd0;
    r = num - (whole == 1 ? den : 64'd0);
    q = 0;
    for (int i = 0; i < TFB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return (whole << TFB) | q;
  endfunction

  function automatic longint lerp_round(longint s, longint d, logic [63:0] t);
    logic [63:0] m, off;
    m = (d < 0 ? -d : d) * t;
    off = (m + (64'd1 << (TFB - 1))) >> TFB;
    return d < 0 ? s - longint'(off) : s + longint'(off);
  endfunction

  function automatic nearest_t nearest_point(pts_t p, logic [THR_W-1:0] thr);
    longint px, py, sx, sy, ex, ey, dx, dy, dot, nx, ny, rx, ry;
    logic [63:0] len2, raw, sq_dist, t;
    nearest_t r;
    case_t which;
    px = longint'($signed(p.px)); py = longint'($signed(p.py));
    sx = longint'($signed(p.sx)); sy = longint'($signed(p.sy));
    ex = longint'($signed(p.ex)); ey = longint'($signed(p.ey));
    dx = ex - sx;
    dy = ey - sy;
    dot = (px - sx) * dx + (py - sy) * dy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0 || dot < 0) begin
      nx = sx; ny = sy; which = CASE_START;
    end else if (64'(dot) > len2) begin
      nx = ex; ny = ey; which = CASE_END;
    end else begin
      t = t_fraction(64'(dot), len2);
      nx = lerp_round(sx, dx, t);
      ny = lerp_round(sy, dy, t);
      which = CASE_INTERIOR;
    end
    rx = px - nx;
    ry = py - ny;
    raw = rx * rx + ry * ry;
    if (FB2 < 32)
      sq_dist = (raw > ({64{1'b1}} >> (32 - FB2))) ? {64{1'b1}} : raw << (32 - FB2);
    else
      sq_dist = raw >> (FB2 - 32);
    if (sq_dist <= {32'd0, thr}) begin
      nx = px; ny = py; sq_dist = 0; which = CASE_ON_SEG;
    end
    r.nx = nx[COORD_W-1:0];
    r.ny = ny[COORD_W-1:0];
    r.sq_dist = sq_dist;
    r.which = which;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    nearest_t e;
    pts_t p;
    if (!rst_n) begin
      threshold <= THR_RESET;
      expected_q.delete();
      errors <= 0;
      pending <= 0;
      results_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (in_valid && !in_stall) begin
        p = '{in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y};
        expected_q.push_back(nearest_point(p, threshold));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(out_which_case), 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_nearest_x !== e.nx) report("nearest_x", 64'(out_nearest_x), 64'(e.nx));
          if (out_nearest_y !== e.ny) report("nearest_y", 64'(out_nearest_y), 64'(e.ny));
          if (out_squared_distance !== e.sq_dist)
            report("squared_distance", out_squared_distance, e.sq_dist);
          if (out_which_case !== e.which)
            report("which_case", 64'(out_which_case), 64'(e.which));
          case_seen[e.which]++;
        end
        results_checked <= results_checked + 1;
      end
      pending <= expected_q.size();
    end
  end

  initial begin
    errors = 0;
    pending = 0;
    results_checked = 0;
    foreach (case_seen[i]) case_seen[i] = 0;
  end
endmodule

// File: test/point_segment_sqr_distance_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for point_segment_sqr_distance_top: directed and random queries,
// threshold changes between phases. Depends on psd_pkg, the top module and the checker module.
module point_segment_sqr_distance_top_tb;
  import psd_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_start_x = '0;
  logic [COORD_W-1:0] in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid, out_stall = 1'b0;
  logic [COORD_W-1:0] out_nearest_x, out_nearest_y;
  logic [DIST_W-1:0] out_squared_distance;
  logic [1:0] out_which_case;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;
  int errors, pending, results_checked;
  int queries_sent = 0;
  int cycles = 0;
  int thresholds_written = 0;

  localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_segment_sqr_distance_top uut (.*);
  point_segment_sqr_distance_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("point_segment_sqr_distance_top test failed");
      $finish;
    end
  end

  // Receiver stall pattern: switch among four behaviors in turn.
  always @(posedge clk) begin
    case ((cycles >> 7) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 9) < 4;
    endcase
  end

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return COORD_W'($urandom);
      2: return COORD_W'($urandom_range(0, 2000) - 1000);
      3: return $urandom_range(0, 1) ? CMIN + COORD_W'($urandom_range(0, 3))
                                     : CMAX - COORD_W'($urandom_range(0, 3));
      default: return COORD_W'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic pts_t random_query();
    pts_t p;
    int sx, sy, ex, ey, k;
    p = '{pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord()};
    case ($urandom_range(0, 5))
      0: begin  // zero-length segment
        p.ex = p.sx;
        p.ey = p.sy;
      end
      1, 2: begin  // point on or very near the segment
        sx = $urandom_range(0, 2000000) - 1000000;
        sy = $urandom_range(0, 2000000) - 1000000;
        ex = $urandom_range(0, 2000000) - 1000000;
        ey = $urandom_range(0, 2000000) - 1000000;
        k = $urandom_range(0, 8);
        p.sx = COORD_W'(sx); p.sy = COORD_W'(sy);
        p.ex = COORD_W'(ex); p.ey = COORD_W'(ey);
        p.px = COORD_W'(sx + ((ex - sx) * k) / 8 + int'($urandom_range(0, 3)));
        p.py = COORD_W'(sy + ((ey - sy) * k) / 8 + int'($urandom_range(0, 3)));
      end
      3: begin  // point at an endpoint
        if ($urandom_range(0, 1)) begin
          p.px = p.ex; p.py = p.ey;
        end else begin
          p.px = p.sx; p.py = p.sy;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_query(pts_t p);
    in_valid <= 1'b1;
    {in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y} <= p;
    do @(posedge clk); while (in_stall);
    queries_sent++;
  endtask

  task automatic send_burst_gap(pts_t p, ref int burst);
    int gap;
    send_query(p);
    if (--burst <= 0) begin
      burst = $urandom_range(1, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until the pipe has drained, then write the threshold.
  task automatic write_threshold(logic [THR_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresholds_written++;
  endtask

  initial begin
    pts_t d[$];
    logic [THR_W-1:0] thr_list[6];
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, degenerate segment, endpoints, exact projection at end
    d.push_back('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    d.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    d.push_back('{CMAX, CMAX, CMIN, CMIN, CMIN, CMIN});
    d.push_back('{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX});
    d.push_back('{CMAX, CMIN, CMIN, CMIN, CMAX, CMAX});
    d.push_back('{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN});
    d.push_back('{CMAX, CMAX, CMIN, CMIN, CMAX, CMAX});
    d.push_back('{31'd500, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0});
    d.push_back('{31'd100, 31'd100, 31'd0, 31'd0, 31'd100, 31'd100});
    d.push_back('{31'd0, 31'd0, 31'd0, 31'd0, 31'd100, 31'd100});
    d.push_back('{-31'sd50, 31'd0, 31'd0, 31'd0, 31'd100, 31'd0});
    d.push_back('{31'd150, 31'd7, 31'd0, 31'd0, 31'd100, 31'd0});
    d.push_back('{31'd100, 31'd9000, 31'd0, 31'd0, 31'd100, 31'd0});
    d.push_back('{31'd33, 31'd9000, 31'd0, 31'd0, 31'd100, 31'd0});
    d.push_back('{31'd1, 31'd0, 31'd0, 31'd0, 31'd3, 31'd0});
    d.push_back('{31'd2, 31'd3, 31'd0, 31'd0, 31'd3, 31'd3});
    d.push_back('{31'd5, 31'd1, -31'sd3, 31'd0, 31'd0, -31'sd3});
    d.push_back('{31'd7, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0});
    d.push_back('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN});
    d.push_back('{31'd0, 31'd0, CMIN, CMAX, CMAX, CMIN});
    foreach (d[i]) send_query(d[i]);

    thr_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, 32'd1000000, 32'd43};
    burst = 5;
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thr_list[ph]);
      for (int i = 0; i < 240; i++) send_burst_gap(random_query(), burst);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d queries over %0d threshold settings; %0d results compared",
             queries_sent, thresholds_written + 1, results_checked);
    $display("cases seen: interior %0d, start %0d, end %0d, on segment %0d",
             chk.case_seen[0], chk.case_seen[1], chk.case_seen[2], chk.case_seen[3]);
    if (errors == 0)
      $display("point_segment_sqr_distance_top test passed");
    else
      $display("point_segment_sqr_distance_top test failed");
    $finish;
  end
endmodule
